// ===== rtl/convex_polygon_sat_collision_macros.svh =====
// Assertion shorthands used by convex_polygon_sat_collision.sv.
`ifndef CONVEX_POLYGON_SAT_COLLISION_MACROS_SVH
`define CONVEX_POLYGON_SAT_COLLISION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPSAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cpsat same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CPSAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cpsat next-cycle check failed");

`endif

// ===== rtl/cpsat_pkg.sv =====
package cpsat_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int COORD_BITS   = 16;

	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int VTX_W  = 2 * COORD_BITS;
	localparam int PROD_W = 2 * COORD_BITS + 1;
	localparam int DOT_W  = 2 * COORD_BITS + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   nrm_t;
	typedef logic signed [DOT_W-1:0]      dot_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	typedef enum logic [1:0] {
		MAC_IDLE,
		MAC_LOAD,
		MAC_ADD
	} mac_op_t;

	typedef struct packed {
		logic upd;
		logic tgt_b;
		logic first;
	} span_ctl_t;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_EDGE0,
		ST_EDGE1,
		ST_NORM,
		ST_MULX,
		ST_MULY,
		ST_CMP,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/cpsat_ram.sv =====
module cpsat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/cpsat_mac.sv =====
module cpsat_mac (
	input  logic              clk,
	input  cpsat_pkg::mac_op_t op,
	input  cpsat_pkg::nrm_t   nx,
	input  cpsat_pkg::nrm_t   ny,
	input  cpsat_pkg::coord_t x,
	input  cpsat_pkg::coord_t y,
	output cpsat_pkg::dot_t   dot
);
	import cpsat_pkg::*;

	nrm_t                    coef;
	coord_t                  data;
	logic signed [PROD_W-1:0] prod;
	dot_t                    prod_x;
	dot_t                    acc_q;

	always_comb begin
		coef   = (op == MAC_ADD) ? ny : nx;
		data   = (op == MAC_ADD) ? y : x;
		prod   = coef * data;
		prod_x = {{(DOT_W - PROD_W){prod[PROD_W-1]}}, prod};
	end

	always_ff @(posedge clk) begin
		unique case (op)
			MAC_LOAD: acc_q <= prod_x;
			MAC_ADD:  acc_q <= acc_q + prod_x;
			MAC_IDLE: acc_q <= acc_q;
			default:  acc_q <= acc_q;
		endcase
	end

	assign dot = acc_q;

endmodule

// ===== rtl/cpsat_span.sv =====
module cpsat_span (
	input  logic                 clk,
	input  cpsat_pkg::span_ctl_t ctl,
	input  cpsat_pkg::dot_t      dot,
	output logic                 overlap
);
	import cpsat_pkg::*;

	dot_t a_lo_q;
	dot_t a_hi_q;
	dot_t b_lo_q;
	dot_t b_hi_q;
	dot_t lo_cur;
	dot_t hi_cur;
	logic below;
	logic above;

	always_comb begin
		lo_cur  = ctl.tgt_b ? b_lo_q : a_lo_q;
		hi_cur  = ctl.tgt_b ? b_hi_q : a_hi_q;
		below   = dot < lo_cur;
		above   = dot > hi_cur;
		overlap = (a_lo_q <= b_hi_q) && (b_lo_q <= a_hi_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.upd) begin
			if (ctl.tgt_b) begin
				if (ctl.first || below) begin
					b_lo_q <= dot;
				end
				if (ctl.first || above) begin
					b_hi_q <= dot;
				end
			end else begin
				if (ctl.first || below) begin
					a_lo_q <= dot;
				end
				if (ctl.first || above) begin
					a_hi_q <= dot;
				end
			end
		end
	end

endmodule

// ===== rtl/convex_polygon_sat_collision.sv =====
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_ready   x, y, last_vertex
// out       source     out_valid / out_ready colliding, overflow
//
// A vertex beat is taken while in_ready is high; A's vertices come first, then B's.
// After B's last vertex the block tests each of the na + nb edge normals in turn on
// the one shared multiply-accumulate unit, projecting every vertex of A and B.
// The test stops at the first separating normal, and in_ready is low throughout it.
// The result sits in an output register, so new vertices load while it waits.
// Reset clears the vertex counts and control flags; vertex memories are not cleared.

`include "convex_polygon_sat_collision_macros.svh"

module convex_polygon_sat_collision (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic signed [cpsat_pkg::COORD_BITS-1:0]   x,
	input  logic signed [cpsat_pkg::COORD_BITS-1:0]   y,
	input  logic                                       last_vertex,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic                                       colliding,
	output logic                                       overflow
);
	import cpsat_pkg::*;

	state_t     state_q;
	state_t     state_d;
	cnt_t       cnt_a_q;
	cnt_t       cnt_b_q;
	cnt_t       n_src;
	cnt_t       n_tgt;
	logic       loading_b_q;
	logic       ovf_q;
	logic       src_b_q;
	logic       tgt_b_q;
	logic       cmp_b_q;
	logic       cmp_first_q;
	logic       cmp_end_q;
	logic       sep_q;
	idx_t       edge_q;
	idx_t       idx_q;
	idx_t       edge_nxt;
	idx_t       addr_edge;
	idx_t       addr_a;
	idx_t       addr_b;
	idx_t       waddr;
	logic       edge_last;
	logic       idx_last;
	logic       edge_phase;
	coord_t     p0x_q;
	coord_t     p0y_q;
	coord_t     src_x;
	coord_t     src_y;
	coord_t     tgt_x;
	coord_t     tgt_y;
	nrm_t       nx_q;
	nrm_t       ny_q;
	logic [VTX_W-1:0] rd_a;
	logic [VTX_W-1:0] rd_b;
	logic [VTX_W-1:0] src_rd;
	logic [VTX_W-1:0] tgt_rd;
	logic [VTX_W-1:0] wdata;
	logic       in_acc;
	logic       cnt_full;
	logic       we_a;
	logic       we_b;
	logic       out_valid_q;
	logic       colliding_q;
	logic       overflow_q;
	logic       out_load;
	mac_op_t    mac_op;
	span_ctl_t  span_ctl;
	dot_t       dot;
	logic       overlap;

	always_comb begin
		n_src     = src_b_q ? cnt_b_q : cnt_a_q;
		n_tgt     = tgt_b_q ? cnt_b_q : cnt_a_q;
		edge_last = (cnt_t'(edge_q) + cnt_t'(1)) == n_src;
		idx_last  = (cnt_t'(idx_q) + cnt_t'(1)) == n_tgt;
		edge_nxt  = edge_last ? '0 : edge_q + idx_t'(1);
		cnt_full  = loading_b_q ? (cnt_b_q == cnt_t'(MAX_VERTICES))
		                        : (cnt_a_q == cnt_t'(MAX_VERTICES));
		waddr     = loading_b_q ? cnt_b_q[IDX_W-1:0] : cnt_a_q[IDX_W-1:0];
		wdata     = {y, x};
		src_rd    = src_b_q ? rd_b : rd_a;
		tgt_rd    = tgt_b_q ? rd_b : rd_a;
		src_x     = coord_t'(src_rd[COORD_BITS-1:0]);
		src_y     = coord_t'(src_rd[VTX_W-1:COORD_BITS]);
		tgt_x     = coord_t'(tgt_rd[COORD_BITS-1:0]);
		tgt_y     = coord_t'(tgt_rd[VTX_W-1:COORD_BITS]);
	end

	always_comb begin
		in_ready   = (state_q == ST_LOAD);
		in_acc     = in_valid && in_ready;
		we_a       = in_acc && !loading_b_q && !cnt_full;
		we_b       = in_acc && loading_b_q && !cnt_full;
		edge_phase = (state_q == ST_EDGE0) || (state_q == ST_EDGE1);
		addr_edge  = (state_q == ST_EDGE1) ? edge_nxt : edge_q;
		addr_a     = (edge_phase && !src_b_q) ? addr_edge : idx_q;
		addr_b     = (edge_phase && src_b_q) ? addr_edge : idx_q;
		out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready);
		span_ctl.upd   = (state_q == ST_CMP);
		span_ctl.tgt_b = cmp_b_q;
		span_ctl.first = cmp_first_q;
		unique case (state_q)
			ST_MULX: mac_op = MAC_LOAD;
			ST_MULY: mac_op = MAC_ADD;
			default: mac_op = MAC_IDLE;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && last_vertex && loading_b_q) begin
					state_d = ST_EDGE0;
				end
			end
			ST_EDGE0: state_d = ST_EDGE1;
			ST_EDGE1: state_d = ST_NORM;
			ST_NORM:  state_d = ST_MULX;
			ST_MULX:  state_d = ST_MULY;
			ST_MULY:  state_d = ST_CMP;
			ST_CMP:   state_d = cmp_end_q ? ST_CHECK : ST_MULX;
			ST_CHECK: begin
				if (!overlap || (edge_last && src_b_q)) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_EDGE0;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_a_q     <= '0;
			cnt_b_q     <= '0;
			loading_b_q <= 1'b0;
			ovf_q       <= 1'b0;
			src_b_q     <= 1'b0;
			tgt_b_q     <= 1'b0;
			edge_q      <= '0;
			idx_q       <= '0;
			cmp_b_q     <= 1'b0;
			cmp_first_q <= 1'b0;
			cmp_end_q   <= 1'b0;
			sep_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (cnt_full) begin
					ovf_q <= 1'b1;
				end else if (loading_b_q) begin
					cnt_b_q <= cnt_b_q + cnt_t'(1);
				end else begin
					cnt_a_q <= cnt_a_q + cnt_t'(1);
				end
				if (last_vertex) begin
					loading_b_q <= 1'b1;
				end
			end
			if (state_q == ST_LOAD) begin
				src_b_q <= 1'b0;
				edge_q  <= '0;
			end
			if ((state_q == ST_LOAD) || (state_q == ST_CHECK)) begin
				idx_q   <= '0;
				tgt_b_q <= 1'b0;
			end
			if (state_q == ST_CHECK) begin
				sep_q <= !overlap;
				if (edge_last) begin
					src_b_q <= 1'b1;
					edge_q  <= '0;
				end else begin
					edge_q <= edge_q + idx_t'(1);
				end
			end
			if (state_q == ST_MULY) begin
				cmp_b_q     <= tgt_b_q;
				cmp_first_q <= (idx_q == '0);
				cmp_end_q   <= tgt_b_q && idx_last;
				if (!idx_last) begin
					idx_q <= idx_q + idx_t'(1);
				end else if (!tgt_b_q) begin
					tgt_b_q <= 1'b1;
					idx_q   <= '0;
				end
			end
			if (out_load) begin
				cnt_a_q     <= '0;
				cnt_b_q     <= '0;
				loading_b_q <= 1'b0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EDGE1) begin
			p0x_q <= src_x;
			p0y_q <= src_y;
		end
		if (state_q == ST_NORM) begin
			nx_q <= nrm_t'(p0y_q) - nrm_t'(src_y);
			ny_q <= nrm_t'(src_x) - nrm_t'(p0x_q);
		end
		if (out_load) begin
			colliding_q <= !sep_q;
			overflow_q  <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign colliding = colliding_q;
	assign overflow  = overflow_q;

	cpsat_ram #(
		.WIDTH(VTX_W),
		.DEPTH(MAX_VERTICES)
	) u_ram_a (
		.clk  (clk),
		.we   (we_a),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(addr_a),
		.rdata(rd_a)
	);

	cpsat_ram #(
		.WIDTH(VTX_W),
		.DEPTH(MAX_VERTICES)
	) u_ram_b (
		.clk  (clk),
		.we   (we_b),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(addr_b),
		.rdata(rd_b)
	);

	cpsat_mac u_mac (
		.clk(clk),
		.op (mac_op),
		.nx (nx_q),
		.ny (ny_q),
		.x  (tgt_x),
		.y  (tgt_y),
		.dot(dot)
	);

	cpsat_span u_span (
		.clk    (clk),
		.ctl    (span_ctl),
		.dot    (dot),
		.overlap(overlap)
	);

	`CPSAT_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1,
		(cnt_a_q <= cnt_t'(MAX_VERTICES)) && (cnt_b_q <= cnt_t'(MAX_VERTICES)))
	`CPSAT_ASSERT_NEXT(a_test_start, clk, arst_n, in_acc && last_vertex && loading_b_q,
		(state_q == ST_EDGE0) && !src_b_q && (cnt_a_q != '0) && (cnt_b_q != '0))
	`CPSAT_ASSERT_NEXT(a_sep_exit, clk, arst_n, (state_q == ST_CHECK) && !overlap,
		(state_q == ST_DONE) && sep_q)
	`CPSAT_ASSERT_NEXT(a_result_clear, clk, arst_n, out_load,
		out_valid && (cnt_a_q == '0) && (cnt_b_q == '0) && !loading_b_q && !ovf_q)

endmodule
